>>> rtl/bis_pkg.sv
package bis_pkg;

	localparam int WORD_BITS = 32;
	localparam int F_BITS    = 48;
	localparam int CNT_BITS  = 6;

	// last iteration row before the forced final row
	localparam logic [CNT_BITS-1:0] MAX_ITER = CNT_BITS'(32);
	localparam logic [WORD_BITS-1:0] TOL_MIN = WORD_BITS'(2);
	localparam logic [WORD_BITS-1:0] TOL_RESET = WORD_BITS'(66);

	// operand select for the square unit
	localparam logic [1:0] SEL_LOWER = 2'd0;
	localparam logic [1:0] SEL_UPPER = 2'd1;
	localparam logic [1:0] SEL_MID   = 2'd2;

	// register byte addresses
	localparam logic [2:0] ADDR_TOLERANCE = 3'd0;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] lower_start;
		logic signed [WORD_BITS-1:0] upper_start;
	} bis_in_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]         row_number;
		logic signed [WORD_BITS-1:0] lower_end;
		logic signed [F_BITS-1:0]    f_lower;
		logic signed [WORD_BITS-1:0] upper_end;
		logic signed [F_BITS-1:0]    f_upper;
		logic signed [WORD_BITS-1:0] midpoint;
		logic signed [F_BITS-1:0]    f_midpoint;
		logic [WORD_BITS-1:0]        width;
		logic                        status;
		logic                        last;
	} bis_out_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] sel;
		logic       fin_en;
		logic       fl_store;
		logic       fh_store;
		logic       mid_en;
		logic       cnt_set1;
		logic       cnt_inc;
		logic       update;
		logic       emit_row;
		logic       emit_last;
		logic       emit_noroot;
	} bis_cmd_t;

	typedef struct packed {
		logic sign_ok;
		logic stop;
	} bis_stat_t;

endpackage

>>> rtl/bisection_root_finder_core.sv
// Bisection root finder for f(x) = x*x - 6x + 8 over a signed Q16.16 start
// interval. Pulse start while busy is low with operands on the port; busy
// rises the next cycle and drops as the last beat appears. Results come out one
// beat per result_valid pulse and cannot be held off, so the receiver must
// take every beat the cycle it appears. An interval without a strict sign
// change of f gives one beat with status set. Otherwise one beat per
// iteration follows, then a final beat (last set) whose midpoint is the root.
// The shared square-and-evaluate unit (multiply, then add/saturate) evaluates
// f at both ends, then once for each row's midpoint; up to 33 rows. The
// no-root beat follows the evaluation of both ends.
module bisection_root_finder_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item port
	input  logic                          start,
	output logic                          busy,
	input  bis_pkg::bis_in_t              operands,
	output bis_pkg::bis_out_t             result,
	output logic                          result_valid,
	// APB register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bis_pkg::*;

	bis_cmd_t             cmd;
	bis_stat_t            stat;
	logic [WORD_BITS-1:0] tolerance_q;
	logic                 tol_hit;
	logic                 busy_int;

	// one register: tolerance at byte 0; bit 2 selects beyond the map
	assign pready  = 1'b1;
	assign tol_hit = (paddr[2] == ADDR_TOLERANCE[2]);
	assign prdata  = tol_hit ? tolerance_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready && tol_hit) begin
			tolerance_q <= pwdata;
		end
	end

	bis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !busy_int),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_int)
	);

	bis_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operands     (operands),
		.tolerance    (tolerance_q),
		.cmd          (cmd),
		.stat         (stat),
		.result       (result),
		.result_valid (result_valid)
	);

	assign busy = busy_int;

`ifndef SYNTHESIS
	// accepted start always begins a search
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after start");

	// a non-final beat means more rows are still coming
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("non-final beat while idle");

	// the no-root beat is the only beat for its item
	a_noroot_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |-> result.last && !busy)
		else $error("no-root beat not final");
`endif

endmodule

>>> rtl/bis_dp.sv
module bis_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bis_pkg::bis_in_t                  operands,
	input  logic [bis_pkg::WORD_BITS-1:0]     tolerance,
	input  bis_pkg::bis_cmd_t                 cmd,
	output bis_pkg::bis_stat_t                stat,
	output bis_pkg::bis_out_t                 result,
	output logic                              result_valid
);
	import bis_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int RW = F_BITS + 3;
	localparam logic signed [RW-1:0] EIGHT = RW'(64'd8 << FRAC_BITS);
	localparam logic signed [RW-1:0] R_MAX = {{(RW-F_BITS+1){1'b0}}, {(F_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] R_MIN = {{(RW-F_BITS+1){1'b1}}, {(F_BITS-1){1'b0}}};

	logic signed [W-1:0]      lower_q, upper_q, mid_q, x_q;
	logic signed [F_BITS-1:0] fl_q, fh_q, f_q;
	logic [2*W-1:0]           prod_q;
	logic [CNT_BITS-1:0]      cnt_q;
	bis_out_t                 result_q;
	logic                     result_valid_q;

	logic signed [W-1:0]      x_sel;
	logic [2*W-1:0]           sq_full;
	logic [F_BITS-2:0]        sq_sat;
	logic signed [RW-1:0]     xe, six_x, r;
	logic signed [F_BITS-1:0] f_next;
	logic signed [W:0]        sum, diff;
	logic [W-1:0]             tol_eff, width_now;
	logic                     opp_mid;

	function automatic logic opposite(logic signed [F_BITS-1:0] p, logic signed [F_BITS-1:0] q);
		logic p_neg, q_neg, p_pos, q_pos;
		p_neg = p[F_BITS-1];
		q_neg = q[F_BITS-1];
		p_pos = !p_neg && (p != '0);
		q_pos = !q_neg && (q != '0);
		return (p_neg && q_pos) || (p_pos && q_neg);
	endfunction

	always_comb begin
		unique case (cmd.sel)
			SEL_LOWER: x_sel = lower_q;
			SEL_UPPER: x_sel = upper_q;
			SEL_MID:   x_sel = mid_q;
			default:   x_sel = mid_q;
		endcase
	end

	// f(x) = floor(x*x / 2^FRAC) - 6x + 8, saturated to the 48-bit range
	assign sq_full = prod_q >> FRAC_BITS;
	assign sq_sat  = (|sq_full[2*W-1:F_BITS-1]) ? '1 : sq_full[F_BITS-2:0];
	assign xe      = RW'(x_q);
	assign six_x   = (xe <<< 2) + (xe <<< 1);
	assign r       = $signed({{(RW-F_BITS+1){1'b0}}, sq_sat}) - six_x + EIGHT;

	always_comb begin
		priority if (r > R_MAX) begin
			f_next = R_MAX[F_BITS-1:0];
		end else if (r < R_MIN) begin
			f_next = R_MIN[F_BITS-1:0];
		end else begin
			f_next = r[F_BITS-1:0];
		end
	end

	assign sum       = {lower_q[W-1], lower_q} + {upper_q[W-1], upper_q};
	assign diff      = {upper_q[W-1], upper_q} - {lower_q[W-1], lower_q};
	assign tol_eff   = (tolerance < TOL_MIN) ? TOL_MIN : tolerance;
	assign width_now = diff[W] ? '0 : diff[W-1:0];
	assign opp_mid   = opposite(f_q, fl_q);

	assign stat.sign_ok = opposite(fl_q, fh_q);
	assign stat.stop    = (diff < $signed({1'b0, tol_eff})) || (cnt_q >= MAX_ITER);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lower_q <= operands.lower_start;
			upper_q <= operands.upper_start;
		end else if (cmd.update) begin
			if (opp_mid) begin
				upper_q <= mid_q;
			end else begin
				lower_q <= mid_q;
			end
		end
		if (cmd.mul_en) begin
			x_q    <= x_sel;
			prod_q <= (2*W)'(x_sel * x_sel);
		end
		if (cmd.fin_en) begin
			f_q <= f_next;
		end
		if (cmd.fl_store || (cmd.update && !opp_mid)) begin
			fl_q <= f_q;
		end
		if (cmd.fh_store || (cmd.update && opp_mid)) begin
			fh_q <= f_q;
		end
		if (cmd.mid_en) begin
			mid_q <= sum[W:1];
		end
		if (cmd.cnt_set1) begin
			cnt_q <= CNT_BITS'(1);
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
		if (cmd.emit_row || cmd.emit_noroot) begin
			result_q.lower_end <= lower_q;
			result_q.f_lower   <= fl_q;
			result_q.upper_end <= upper_q;
			result_q.f_upper   <= fh_q;
			result_q.width     <= width_now;
			if (cmd.emit_noroot) begin
				result_q.row_number <= '0;
				result_q.midpoint   <= '0;
				result_q.f_midpoint <= '0;
				result_q.status     <= 1'b1;
				result_q.last       <= 1'b1;
			end else begin
				result_q.row_number <= cnt_q;
				result_q.midpoint   <= mid_q;
				result_q.f_midpoint <= f_q;
				result_q.status     <= 1'b0;
				result_q.last       <= cmd.emit_last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.emit_row || cmd.emit_noroot;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

>>> rtl/bis_ctrl.sv
module bis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  bis_pkg::bis_stat_t stat,
	output bis_pkg::bis_cmd_t  cmd,
	output logic               busy
);
	import bis_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ML   = 4'd1;
	localparam logic [3:0] ST_FL   = 4'd2;
	localparam logic [3:0] ST_SL   = 4'd3;
	localparam logic [3:0] ST_FU   = 4'd4;
	localparam logic [3:0] ST_CHK  = 4'd5;
	localparam logic [3:0] ST_DEC  = 4'd6;
	localparam logic [3:0] ST_MM   = 4'd7;
	localparam logic [3:0] ST_MF   = 4'd8;
	localparam logic [3:0] ST_ROW  = 4'd9;
	localparam logic [3:0] ST_MID  = 4'd10;

	logic [3:0] state_q, state_d;
	logic       final_q, final_d;

	always_comb begin
		cmd     = '0;
		cmd.sel = SEL_MID;
		state_d = state_q;
		final_d = final_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_ML;
				end
			end
			ST_ML: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = SEL_LOWER;
				state_d    = ST_FL;
			end
			ST_FL: begin
				cmd.fin_en = 1'b1;
				state_d    = ST_SL;
			end
			ST_SL: begin
				cmd.fl_store = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.sel      = SEL_UPPER;
				state_d      = ST_FU;
			end
			ST_FU: begin
				cmd.fin_en = 1'b1;
				state_d    = ST_CHK;
			end
			ST_CHK: begin
				cmd.fh_store = 1'b1;
				state_d      = ST_DEC;
			end
			ST_DEC: begin
				if (!stat.sign_ok) begin
					cmd.emit_noroot = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.cnt_set1 = 1'b1;
					cmd.mid_en   = 1'b1;
					final_d      = 1'b0;
					state_d      = ST_MM;
				end
			end
			ST_MM: begin
				cmd.mul_en = 1'b1;
				cmd.sel    = SEL_MID;
				state_d    = ST_MF;
			end
			ST_MF: begin
				cmd.fin_en = 1'b1;
				state_d    = ST_ROW;
			end
			ST_ROW: begin
				cmd.emit_row  = 1'b1;
				cmd.emit_last = final_q;
				if (final_q) begin
					state_d = ST_IDLE;
				end else begin
					cmd.update = 1'b1;
					state_d    = ST_MID;
				end
			end
			ST_MID: begin
				cmd.mid_en  = 1'b1;
				cmd.cnt_inc = 1'b1;
				final_d     = stat.stop;
				state_d     = ST_MM;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			final_q <= 1'b0;
		end else begin
			state_q <= state_d;
			final_q <= final_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> dv/bisection_row_checker.sv
module bisection_row_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  bis_pkg::bis_in_t  operands,
	input  bis_pkg::bis_out_t result,
	input  logic              result_valid,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int unsigned       mismatches,
	output int unsigned       rows_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bis_pkg::*;

	localparam longint F_TOP    = (longint'(1) <<< (F_BITS - 1)) - 1;
	localparam longint F_BOTTOM = -F_TOP - 1;
	localparam longint WORD_TOP = (longint'(1) <<< WORD_BITS) - 1;

	logic [WORD_BITS-1:0] tolerance = TOL_RESET;
	bis_out_t             rows_due[$];
	int unsigned          bad_beats = 0;
	int unsigned          due_count = 0;

	assign mismatches   = bad_beats;
	assign rows_pending = due_count;

	// x*x - 6x + 8 in Q32.16, square floored, result clamped to 48 bits
	function automatic longint quad(longint x);
		longint mag;
		longint r;
		mag = (x < 0) ? -x : x;
		r = ((mag * mag) >>> FRAC_BITS) - 6 * x + (longint'(8) <<< FRAC_BITS);
		if (r > F_TOP)
			r = F_TOP;
		if (r < F_BOTTOM)
			r = F_BOTTOM;
		return r;
	endfunction

	function automatic longint half_point(longint a, longint b);
		return (a + b) >>> 1;
	endfunction

	function automatic logic [WORD_BITS-1:0] span(longint a, longint b);
		longint d;
		d = b - a;
		if (d < 0)
			return '0;
		if (d > WORD_TOP)
			return '1;
		return d[WORD_BITS-1:0];
	endfunction

	function automatic bit straddles(longint p, longint q);
		return (p < 0 && q > 0) || (p > 0 && q < 0);
	endfunction

	function automatic bis_out_t make_row(logic [CNT_BITS-1:0] row, longint a, longint fa,
			longint b, longint fb, longint c, longint fc, logic status, logic last);
		bis_out_t r;
		r.row_number = row;
		r.lower_end  = a[WORD_BITS-1:0];
		r.f_lower    = fa[F_BITS-1:0];
		r.upper_end  = b[WORD_BITS-1:0];
		r.f_upper    = fb[F_BITS-1:0];
		r.midpoint   = c[WORD_BITS-1:0];
		r.f_midpoint = fc[F_BITS-1:0];
		r.width      = span(a, b);
		r.status     = status;
		r.last       = last;
		return r;
	endfunction

	// all rows one interval gives, appended to rows_due
	task automatic plan_rows(bis_in_t item);
		longint lo, hi, flo, fhi, a, b, fa, c, fc, tol;
		logic [CNT_BITS-1:0] step;
		lo  = longint'(item.lower_start);
		hi  = longint'(item.upper_start);
		flo = quad(lo);
		fhi = quad(hi);
		tol = longint'((tolerance < TOL_MIN) ? TOL_MIN : tolerance);
		if (!straddles(flo, fhi)) begin
			rows_due.push_back(make_row('0, lo, flo, hi, fhi, 0, 0, 1'b1, 1'b1));
			return;
		end
		a    = lo;
		b    = hi;
		fa   = flo;
		step = CNT_BITS'(1);
		forever begin
			c  = half_point(a, b);
			fc = quad(c);
			rows_due.push_back(make_row(step, a, fa, b, quad(b), c, fc, 1'b0, 1'b0));
			if (straddles(fc, fa)) begin
				b = c;
			end else begin
				a  = c;
				fa = fc;
			end
			if (b - a < tol || step >= MAX_ITER) begin
				c = half_point(a, b);
				rows_due.push_back(make_row(CNT_BITS'(step + 1), a, fa, b, quad(b), c,
					quad(c), 1'b0, 1'b1));
				break;
			end
			step++;
		end
	endtask

	function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 1'b0;
		if (bad_beats < 10)
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		return 1'b1;
	endfunction

	task automatic check_row(bis_out_t got);
		bis_out_t want;
		bit       bad;
		if (rows_due.size() == 0) begin
			if (bad_beats < 10)
				$display("%0t: result beat with nothing outstanding, row %0d",
					$time, got.row_number);
			bad_beats++;
			return;
		end
		want = rows_due.pop_front();
		bad  = 1'b0;
		bad |= field_differs("row_number", want.row_number, got.row_number);
		bad |= field_differs("lower_end",  want.lower_end,  got.lower_end);
		bad |= field_differs("f_lower",    want.f_lower,    got.f_lower);
		bad |= field_differs("upper_end",  want.upper_end,  got.upper_end);
		bad |= field_differs("f_upper",    want.f_upper,    got.f_upper);
		bad |= field_differs("midpoint",   want.midpoint,   got.midpoint);
		bad |= field_differs("f_midpoint", want.f_midpoint, got.f_midpoint);
		bad |= field_differs("width",      want.width,      got.width);
		bad |= field_differs("status",     want.status,     got.status);
		bad |= field_differs("last",       want.last,       got.last);
		if (bad)
			bad_beats++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			tolerance = TOL_RESET;
			rows_due.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == ADDR_TOLERANCE[2])
				tolerance = pwdata;
			if (start && !busy)
				plan_rows(operands);
			if (result_valid)
				check_row(result);
		end
		due_count <= rows_due.size();
	end

endmodule

>>> dv/bisection_root_finder_core_test.sv
module bisection_root_finder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bis_pkg::*;

	// Q16.16 landmarks: f(x) = x*x - 6x + 8 has its roots at 2.0 and 4.0
	localparam longint Q_ONE     = longint'(1) <<< 16;
	localparam longint ROOT_LOW  = 2 * Q_ONE;
	localparam longint ROOT_HIGH = 4 * Q_ONE;
	localparam longint WORD_MIN  = -(longint'(1) <<< 31);
	localparam longint WORD_MAX  = (longint'(1) <<< 31) - 1;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	bis_in_t     operands;
	bis_out_t    result;
	logic        result_valid;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned mismatches;
	int unsigned rows_pending;
	bit          gaps_on;

	always #4 clk = ~clk;

	bisection_root_finder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operands     (operands),
		.result       (result),
		.result_valid (result_valid),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Watches both channels and the register port, predicts every row beat
	// and compares; we only read back its counters.
	bisection_row_checker i_rows (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operands     (operands),
		.result       (result),
		.result_valid (result_valid),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.rows_pending (rows_pending)
	);

	// Everything below is called at a falling edge and returns at one, so the
	// block only ever sees inputs that settled half a period before its edge.

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_tolerance(input logic [31:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_TOLERANCE;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// One interval beat. start is left high on return; busy is already up by
	// then, so the stale beat cannot be taken again. Whoever waits next drops
	// start first (a gap or settle()).
	task automatic send_interval(input longint lo, input longint hi);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start                = 1'b1;
		operands.lower_start = lo[31:0];
		operands.upper_start = hi[31:0];
		// busy read right at the edge is the value the block saw there
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Hold the sender until every predicted row has come back and the block
	// has dropped busy. Also the only safe point for a register write.
	task automatic settle();
		start = 1'b0;
		while (rows_pending != 0 || busy)
			@(negedge clk);
	endtask

	// 1..limit with magnitudes spread over all bit lengths, so both tiny and
	// huge spans show up.
	function automatic longint reach(longint limit);
		longint v;
		v = longint'($urandom >> $urandom_range(0, 31));
		return 1 + v % limit;
	endfunction

	// Mostly intervals around one root (deep bisection), some reversed,
	// a quarter raw bits (mostly no sign change, but toggles every bit).
	task automatic pick_interval(output longint lo, output longint hi);
		int unsigned kind;
		longint      swap;
		kind = $urandom_range(0, 99);
		if (kind >= 75) begin
			lo = $urandom;
			hi = $urandom;
			return;
		end
		if ($urandom_range(0, 1) == 0) begin
			// lower anywhere below 2.0, upper strictly between the roots
			lo = ROOT_LOW - reach(ROOT_LOW - WORD_MIN);
			hi = ROOT_LOW + reach(ROOT_LOW - 1);
		end else begin
			lo = ROOT_HIGH - reach(ROOT_LOW - 1);
			hi = ROOT_HIGH + reach(WORD_MAX - ROOT_HIGH);
		end
		if (kind >= 60) begin
			swap = lo;
			lo   = hi;
			hi   = swap;
		end
	endtask

	initial begin
		logic [31:0] phase_tol[7];
		longint      lo, hi;

		arst_n   = 1'b0;
		start    = 1'b0;
		operands = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		gaps_on  = 1'b1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed, reset tolerance of 66 LSB ---
		send_interval(Q_ONE, 3 * Q_ONE);            // midpoint lands on root 2 exactly
		send_interval(3 * Q_ONE, 5 * Q_ONE);        // midpoint lands on root 4 exactly
		send_interval(0, 3 * Q_ONE);
		send_interval(ROOT_LOW, 3 * Q_ONE);         // f(lower) zero: no root
		send_interval(3 * Q_ONE, ROOT_HIGH);        // f(upper) zero: no root
		send_interval(0, Q_ONE);                    // same sign at both ends
		send_interval(3 * Q_ONE, Q_ONE);            // reversed, still a sign change
		send_interval(WORD_MIN, 3 * Q_ONE);
		send_interval(3 * Q_ONE, WORD_MAX);
		send_interval(WORD_MIN, WORD_MAX);          // widest, no sign change
		send_interval(WORD_MAX, WORD_MIN);          // reversed extremes, width 0
		send_interval(3 * Q_ONE, 3 * Q_ONE);        // empty interval
		send_interval(ROOT_LOW - 1, ROOT_LOW + 1);  // already narrower than tolerance

		// tolerance 0 and 1 both behave as 2; widest span runs into the row cap
		settle();
		write_tolerance(32'd0);
		send_interval(WORD_MIN, 3 * Q_ONE);
		send_interval(3 * Q_ONE / 2, 5 * Q_ONE / 2);
		settle();
		write_tolerance(32'd1);
		send_interval(3 * Q_ONE, WORD_MAX);

		// huge tolerance: one row then the final row
		settle();
		write_tolerance(32'hFFFF_FFFF);
		send_interval(0, 3 * Q_ONE);
		send_interval(WORD_MIN, 3 * Q_ONE);

		settle();
		write_tolerance(TOL_MIN);
		send_interval(7 * Q_ONE / 2, WORD_MAX);
		send_interval(WORD_MIN, 5 * Q_ONE / 2);

		// --- random phases, one tolerance each; no sender gaps in the last ---
		phase_tol[0] = TOL_MIN;
		phase_tol[1] = 32'd66;
		phase_tol[2] = 32'h0001_0000;
		phase_tol[3] = $urandom_range(2, 1 << 20);
		phase_tol[4] = $urandom;
		phase_tol[5] = 32'hFFFF_FFFF;
		phase_tol[6] = 32'd1000;
		for (int p = 0; p < 7; p++) begin
			settle();
			write_tolerance(phase_tol[p]);
			gaps_on = (p != 6);
			repeat (40) begin
				pick_interval(lo, hi);
				send_interval(lo, hi);
				// now and then drain completely before the next beat
				if (gaps_on && $urandom_range(0, 39) == 0)
					settle();
			end
		end

		// drain, then watch a full worst-case item time for stray beats
		settle();
		repeat (150) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// worst case is roughly 310 items plus gaps, well under 0.5 ms
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
